FILE: hdl/pnom_pkg.sv
// ----------------------------------------------------------------------------
// pnom_pkg
// Shared types and constants for the pulse/noise oscillator mixer.
// ----------------------------------------------------------------------------
package pnom_pkg;

   // Sample divider reload value (samples per tick counter step)
   localparam logic [7:0]  TICK_DIV     = 8'd16;

   // Noise generator
   localparam logic [15:0] LFSR_SEED    = 16'h0001;
   localparam logic [15:0] LFSR_TAPS    = 16'h002D;

   // Mixer
   localparam int          MIX_W        = 12;
   localparam logic signed [MIX_W-1:0] MIX_BIAS = 12'sd512;
   localparam logic signed [MIX_W-1:0] MIX_MAX  = 12'sd1023;

   // Tick counter value that marks a due consumer
   localparam logic [7:0]  TICK_DUE     = 8'd255;

   // CSR register indexes
   localparam logic [1:0]  CSR_PRESET_ZERO = 2'd0;
   localparam logic [1:0]  CSR_PRESET_ONE  = 2'd1;
   localparam logic [1:0]  CSR_ENABLE_ZERO = 2'd2;
   localparam logic [1:0]  CSR_ENABLE_ONE  = 2'd3;

   typedef struct packed {
      logic [7:0] preset_zero;
      logic [7:0] preset_one;
      logic       enable_zero;
      logic       enable_one;
   } tick_cfg_type;

   typedef struct packed {
      logic div_event;
      logic fire_zero;
      logic fire_one;
   } tick_status_type;

endpackage

FILE: hdl/pnom_pulse_ch.sv
// ----------------------------------------------------------------------------
// pnom_pulse_ch
// One pulse channel: phase accumulator and signed mix contribution.
// ----------------------------------------------------------------------------
module pnom_pulse_ch (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        vol,
   input  logic [15:0]       step,
   input  logic [7:0]        duty,
   output logic signed [8:0] term
);

   logic [15:0] acc_ff;
   logic [15:0] acc_in;
   logic [15:0] acc_sum;
   logic        active;

   assign active  = (vol != 8'd0);
   assign acc_sum = acc_ff + step;
   assign acc_in  = (advance && active) ? acc_sum : acc_ff;

   // High byte above the duty threshold: positive half of the pulse
   always_comb begin
      if (!active) begin
         term = 9'sd0;
      end else if (acc_sum[15:8] > duty) begin
         term = $signed({1'b0, vol});
      end else begin
         term = -$signed({1'b0, vol});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 16'd0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

FILE: hdl/pnom_noise.sv
// ----------------------------------------------------------------------------
// pnom_noise
// Noise channel: 16-bit Galois LFSR, shifted-out bit picks the sign.
// ----------------------------------------------------------------------------
module pnom_noise (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        vol,
   output logic signed [8:0] term
);

   logic [15:0] lfsr_ff;
   logic [15:0] lfsr_in;
   logic [15:0] lfsr_next;
   logic        active;
   logic        top_bit;

   assign active    = (vol != 8'd0);
   assign top_bit   = lfsr_ff[15];
   assign lfsr_next = {lfsr_ff[14:0], 1'b0} ^ (top_bit ? pnom_pkg::LFSR_TAPS : 16'd0);
   assign lfsr_in   = (advance && active) ? lfsr_next : lfsr_ff;

   always_comb begin
      if (!active) begin
         term = 9'sd0;
      end else if (top_bit) begin
         term = $signed({1'b0, vol});
      end else begin
         term = -$signed({1'b0, vol});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= pnom_pkg::LFSR_SEED;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

endmodule

FILE: hdl/pnom_tick.sv
// ----------------------------------------------------------------------------
// pnom_tick
// Sample divider and the two tick counters with their service logic.
// ----------------------------------------------------------------------------
module pnom_tick (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  pnom_pkg::tick_cfg_type    cfg,
   output pnom_pkg::tick_status_type status
);

   logic [7:0] divider_ff;
   logic [7:0] divider_in;
   logic [7:0] divider_dec;
   logic [7:0] count0_ff;
   logic [7:0] count0_in;
   logic [7:0] count1_ff;
   logic [7:0] count1_in;
   logic [7:0] count0_dec;
   logic [7:0] count1_dec;
   logic       div_event;
   logic       due0;
   logic       due1;
   logic       service;

   assign divider_dec = divider_ff - 8'd1;
   assign div_event   = (divider_dec == 8'd0);
   assign count0_dec  = count0_ff - 8'd1;
   assign count1_dec  = count1_ff - 8'd1;
   assign due0        = (count0_dec == pnom_pkg::TICK_DUE);
   assign due1        = (count1_dec == pnom_pkg::TICK_DUE);
   assign service     = div_event && (due0 || due1);

   always_comb begin
      divider_in       = divider_ff;
      count0_in        = count0_ff;
      count1_in        = count1_ff;
      status.div_event = advance && div_event;
      status.fire_zero = 1'b0;
      status.fire_one  = 1'b0;
      if (advance) begin
         divider_in = div_event ? pnom_pkg::TICK_DIV : divider_dec;
         if (div_event) begin
            count0_in = count0_dec;
            count1_in = count1_dec;
         end
         if (service) begin
            // Due counter reloads; idle one with no consumer parks at 255
            if (due0) begin
               count0_in        = cfg.preset_zero;
               status.fire_zero = cfg.enable_zero;
            end else if (!cfg.enable_zero) begin
               count0_in = pnom_pkg::TICK_DUE;
            end
            if (due1) begin
               count1_in       = cfg.preset_one;
               status.fire_one = cfg.enable_one;
            end else if (!cfg.enable_one) begin
               count1_in = pnom_pkg::TICK_DUE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= 8'd0;
         count0_ff  <= 8'd0;
         count1_ff  <= 8'd0;
      end else begin
         divider_ff <= divider_in;
         count0_ff  <= count0_in;
         count1_ff  <= count1_in;
      end
   end

endmodule

FILE: hdl/pulse_noise_oscillator_mixer.sv
// ----------------------------------------------------------------------------
// pulse_noise_oscillator_mixer
// Three pulse channels and an LFSR noise channel mixed into a clamped 10-bit
// PCM level, plus a sample divider driving two tick counters.
// ----------------------------------------------------------------------------
// rsp_valid is set in the cycle after a req transfer (result register).
// Throughput: 1 sample per cycle while the result side is ready; the mix is
//   one pass of adders and a clamp between the req side and the result register.
// Reset: synchronous, active high; phase accumulators and tick counters to 0,
//   LFSR to 1, divider to 0, CSRs to 0, result register empty.
// ----------------------------------------------------------------------------
module pulse_noise_oscillator_mixer (
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_vol_a,
   input  logic [7:0]  req_vol_b,
   input  logic [7:0]  req_vol_c,
   input  logic [7:0]  req_vol_noise,
   input  logic [15:0] req_step_a,
   input  logic [15:0] req_step_b,
   input  logic [15:0] req_step_c,
   input  logic [7:0]  req_duty_a,
   input  logic [7:0]  req_duty_b,
   input  logic [7:0]  req_duty_c,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_pcm_level,
   output logic        rsp_tick_fire_zero,
   output logic        rsp_tick_fire_one,
   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int W = pnom_pkg::MIX_W;

   // ---------------------------------------------------------------------
   // CSRs: preset/enable for the two tick consumers, word addressed
   // ---------------------------------------------------------------------
   pnom_pkg::tick_cfg_type cfg_ff;
   pnom_pkg::tick_cfg_type cfg_in;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            pnom_pkg::CSR_PRESET_ZERO: cfg_in.preset_zero = csr_pwdata[7:0];
            pnom_pkg::CSR_PRESET_ONE:  cfg_in.preset_one  = csr_pwdata[7:0];
            pnom_pkg::CSR_ENABLE_ZERO: cfg_in.enable_zero = csr_pwdata[0];
            pnom_pkg::CSR_ENABLE_ONE:  cfg_in.enable_one  = csr_pwdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         pnom_pkg::CSR_PRESET_ZERO: csr_prdata = {24'd0, cfg_ff.preset_zero};
         pnom_pkg::CSR_PRESET_ONE:  csr_prdata = {24'd0, cfg_ff.preset_one};
         pnom_pkg::CSR_ENABLE_ZERO: csr_prdata = {31'd0, cfg_ff.enable_zero};
         pnom_pkg::CSR_ENABLE_ONE:  csr_prdata = {31'd0, cfg_ff.enable_one};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: take a new sample whenever the result register is empty or
   // is being drained in the same cycle.
   // ---------------------------------------------------------------------
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic accept;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   // ---------------------------------------------------------------------
   // Oscillators; state only moves on a req transfer
   // ---------------------------------------------------------------------
   logic signed [8:0] term_a;
   logic signed [8:0] term_b;
   logic signed [8:0] term_c;
   logic signed [8:0] term_n;

   pnom_pulse_ch u_ch_a (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .vol     (req_vol_a),
      .step    (req_step_a),
      .duty    (req_duty_a),
      .term    (term_a)
   );

   pnom_pulse_ch u_ch_b (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .vol     (req_vol_b),
      .step    (req_step_b),
      .duty    (req_duty_b),
      .term    (term_b)
   );

   pnom_pulse_ch u_ch_c (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .vol     (req_vol_c),
      .step    (req_step_c),
      .duty    (req_duty_c),
      .term    (term_c)
   );

   pnom_noise u_noise (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .vol     (req_vol_noise),
      .term    (term_n)
   );

   // ---------------------------------------------------------------------
   // Tick divider and counters
   // ---------------------------------------------------------------------
   pnom_pkg::tick_status_type tick_status;

   pnom_tick u_tick (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .cfg     (cfg_ff),
      .status  (tick_status)
   );

   // ---------------------------------------------------------------------
   // Mix: bias plus four signed terms, range -508..1532, then clamp
   // ---------------------------------------------------------------------
   logic signed [W-1:0] mix_sum;
   logic [9:0]          mix_clamped;

   assign mix_sum = pnom_pkg::MIX_BIAS
                  + W'(term_a) + W'(term_b) + W'(term_c) + W'(term_n);

   always_comb begin
      if (mix_sum < 0) begin
         mix_clamped = 10'd0;
      end else if (mix_sum > pnom_pkg::MIX_MAX) begin
         mix_clamped = 10'd1023;
      end else begin
         mix_clamped = mix_sum[9:0];
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   logic [9:0] pcm_ff;
   logic       fire0_ff;
   logic       fire1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pcm_ff   <= mix_clamped;
         fire0_ff <= tick_status.fire_zero;
         fire1_ff <= tick_status.fire_one;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pcm_level      = pcm_ff;
   assign rsp_tick_fire_zero = fire0_ff;
   assign rsp_tick_fire_one  = fire1_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // every req transfer leaves a result behind
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("req transfer did not produce a result");

   // an empty result register never stalls the sample side
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty result register");

   // a tick flag only comes out of a divider event
   a_fire_on_event: assert property (@(posedge clock) disable iff (reset)
      (tick_status.fire_zero || tick_status.fire_one) |-> tick_status.div_event)
      else $error("tick flag raised without a divider event");

endmodule

FILE: tb/sv/pulse_noise_oscillator_mixer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_noise_oscillator_mixer_test
// Self-checking bench for the pulse/noise mixer. A short table of directed
// samples is followed by random samples over several tick counter settings.
// Every result transfer is compared with its table result or a cycle-free model
// of the mixer, the noise generator, the sample divider and the tick counters.
// ----------------------------------------------------------------------------
module pulse_noise_oscillator_mixer_test;

   // One sample in port order, so it can be driven as one concatenation.
   typedef struct packed {
      logic [7:0]  vol_a;
      logic [7:0]  vol_b;
      logic [7:0]  vol_c;
      logic [7:0]  vol_noise;
      logic [15:0] step_a;
      logic [15:0] step_b;
      logic [15:0] step_c;
      logic [7:0]  duty_a;
      logic [7:0]  duty_b;
      logic [7:0]  duty_c;
   } sample_type;

   typedef struct packed {
      logic [9:0] pcm_level;
      logic       fire_zero;
      logic       fire_one;
   } mix_result_type;

   // known = 1: the row carries its own result, else the model supplies it
   typedef struct packed {
      sample_type     sample;
      logic           known;
      mix_result_type result;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam int PHASES        = 5;
   localparam int RANDOM_PHASE  = 3;   // presets and enables drawn at random
   localparam int STEADY_PHASE  = 2;   // no idling on either side

   // Directed samples, right after reset (phases 0, LFSR 1, divider 256
   // samples away from its first event, so no tick fires in this table).
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // everything muted: bias only
      '{'{8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'd0},
        1'b1, '{10'd512, 1'b0, 1'b0}},
      // full volume, zero step: all low, noise subtracts too, clamps at 0
      '{'{8'd255, 8'd255, 8'd255, 8'd255, 16'h0000, 16'h0000, 16'h0000,
          8'd0, 8'd0, 8'd0}, 1'b1, '{10'd0, 1'b0, 1'b0}},
      // step to 0xFFFF: all high, clamps at 1023
      '{'{8'd255, 8'd255, 8'd255, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          8'd0, 8'd0, 8'd0}, 1'b1, '{10'd1023, 1'b0, 1'b0}},
      // accumulators wrap to zero
      '{'{8'd255, 8'd255, 8'd255, 8'd0, 16'h0001, 16'h0001, 16'h0001,
          8'd0, 8'd0, 8'd0}, 1'b1, '{10'd0, 1'b0, 1'b0}},
      // high byte 0xFF does not exceed duty 0xFF
      '{'{8'd1, 8'd1, 8'd1, 8'd0, 16'hFF00, 16'hFF00, 16'hFF00,
          8'd255, 8'd255, 8'd255}, 1'b1, '{10'd509, 1'b0, 1'b0}},
      // zero volume freezes the phase whatever the step
      '{'{8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'h1234, 16'h8000, 8'd0, 8'd0, 8'd0},
        1'b1, '{10'd512, 1'b0, 1'b0}},
      // noise alone: walk the LFSR up until its top bit shifts out
      '{'{8'd0, 8'd0, 8'd0, 8'd1,   16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd2,   16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd4,   16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd8,   16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd16,  16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd32,  16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd64,  16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd128, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd255, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd3,   16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd200, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd77,  16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd100, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd17,  16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      // top bit set here: noise adds and the taps go in
      '{'{8'd0, 8'd0, 8'd0, 8'd255, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      // each pulse channel alone, near half duty
      '{'{8'd100, 8'd0, 8'd0, 8'd0, 16'h4000, 16'h0000, 16'h0000,
          8'd127, 8'd0, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd100, 8'd0, 8'd0, 16'h0000, 16'h8100, 16'h0000,
          8'd0, 8'd127, 8'd0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd60, 8'd0, 16'h0000, 16'h0000, 16'h0080,
          8'd0, 8'd0, 8'd127}, 1'b0, '0},
      // all four together
      '{'{8'd200, 8'd150, 8'd90, 8'd255, 16'h1357, 16'h2468, 16'hFEDC,
          8'h10, 8'h80, 8'hF0}, 1'b0, '0}
   };

   // Tick counter settings, one per phase after the default one.
   // The entry at RANDOM_PHASE is replaced by a random draw.
   pnom_pkg::tick_cfg_type tick_settings [PHASES] = '{
      '{8'd0,   8'd0,   1'b1, 1'b1},
      '{8'd255, 8'd2,   1'b1, 1'b0},
      '{8'd3,   8'd255, 1'b0, 1'b1},
      '{8'd0,   8'd0,   1'b0, 1'b0},
      '{8'd1,   8'd0,   1'b1, 1'b1}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_vol_a = '0;
   logic [7:0]  req_vol_b = '0;
   logic [7:0]  req_vol_c = '0;
   logic [7:0]  req_vol_noise = '0;
   logic [15:0] req_step_a = '0;
   logic [15:0] req_step_b = '0;
   logic [15:0] req_step_c = '0;
   logic [7:0]  req_duty_a = '0;
   logic [7:0]  req_duty_b = '0;
   logic [7:0]  req_duty_c = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [9:0]  rsp_pcm_level;
   logic        rsp_tick_fire_zero;
   logic        rsp_tick_fire_one;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Mixer model state, same reset values as the block
   logic [15:0] phase_accum [3] = '{default: 16'h0000};
   logic [15:0] noise_reg = pnom_pkg::LFSR_SEED;
   logic [7:0]  div_count = 8'd0;
   logic [7:0]  tick_count [2] = '{default: 8'd0};
   logic [7:0]  tick_reload [2] = '{default: 8'd0};
   logic        tick_on [2] = '{default: 1'b0};

   mix_result_type pending_mixes [$];   // results owed by the block, oldest first
   int             mismatch_count = 0;
   bit             steady = 1'b0;       // suppresses idling on both sides

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   pulse_noise_oscillator_mixer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_vol_a          (req_vol_a),
      .req_vol_b          (req_vol_b),
      .req_vol_c          (req_vol_c),
      .req_vol_noise      (req_vol_noise),
      .req_step_a         (req_step_a),
      .req_step_b         (req_step_b),
      .req_step_c         (req_step_c),
      .req_duty_a         (req_duty_a),
      .req_duty_b         (req_duty_b),
      .req_duty_c         (req_duty_c),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pcm_level      (rsp_pcm_level),
      .rsp_tick_fire_zero (rsp_tick_fire_zero),
      .rsp_tick_fire_one  (rsp_tick_fire_one),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // Advance the model by one sample and return the result it owes.
   function automatic mix_result_type mix_sample(input sample_type s);
      logic [7:0]     vol [3];
      logic [15:0]    step [3];
      logic [7:0]     duty [3];
      logic           fired [2];
      logic           top;
      int             level;
      int             ch;
      mix_result_type r;
      vol   = '{s.vol_a, s.vol_b, s.vol_c};
      step  = '{s.step_a, s.step_b, s.step_c};
      duty  = '{s.duty_a, s.duty_b, s.duty_c};
      fired = '{1'b0, 1'b0};
      level = int'(pnom_pkg::MIX_BIAS);

      // pulse channels: muted ones keep their phase
      for (ch = 0; ch < 3; ch++) begin
         if (vol[ch] != 8'd0) begin
            phase_accum[ch] = phase_accum[ch] + step[ch];
            if (phase_accum[ch][15:8] > duty[ch])
               level += int'(vol[ch]);
            else
               level -= int'(vol[ch]);
         end
      end

      // noise: Galois shift left, the bit shifted out picks the sign
      if (s.vol_noise != 8'd0) begin
         top = noise_reg[15];
         noise_reg = {noise_reg[14:0], 1'b0} ^ (top ? pnom_pkg::LFSR_TAPS : 16'h0000);
         if (top)
            level += int'(s.vol_noise);
         else
            level -= int'(s.vol_noise);
      end

      if (level < 0)
         level = 0;
      if (level > int'(pnom_pkg::MIX_MAX))
         level = int'(pnom_pkg::MIX_MAX);

      // divider event every TICK_DIV samples, first one 256 after reset
      div_count = div_count - 8'd1;
      if (div_count == 8'd0) begin
         div_count = pnom_pkg::TICK_DIV;
         tick_count[0] = tick_count[0] - 8'd1;
         tick_count[1] = tick_count[1] - 8'd1;
         if (tick_count[0] == pnom_pkg::TICK_DUE ||
             tick_count[1] == pnom_pkg::TICK_DUE) begin
            for (ch = 0; ch < 2; ch++) begin
               if (tick_count[ch] != pnom_pkg::TICK_DUE) begin
                  // an absent consumer is parked at the due value
                  if (!tick_on[ch])
                     tick_count[ch] = pnom_pkg::TICK_DUE;
               end else begin
                  fired[ch] = tick_on[ch];
                  tick_count[ch] = tick_reload[ch];
               end
            end
         end
      end

      r.pcm_level = level[9:0];
      r.fire_zero = fired[0];
      r.fire_one  = fired[1];
      return r;
   endfunction

   // Extremes a fifth of the time, otherwise uniform.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [15:0] pick_step();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(255));
         3: return 16'hFF00 | 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      s.vol_a     = pick_byte();
      s.vol_b     = pick_byte();
      s.vol_c     = pick_byte();
      s.vol_noise = pick_byte();
      s.step_a    = pick_step();
      s.step_b    = pick_step();
      s.step_c    = pick_step();
      s.duty_a    = pick_byte();
      s.duty_b    = pick_byte();
      s.duty_c    = pick_byte();
      return s;
   endfunction

   // Offer one sample, wait for its transfer, then log what it owes.
   // Valid is left high; the next call either keeps it or idles first.
   task automatic send_sample(input sample_type s, input logic known,
                              input mix_result_type typed);
      mix_result_type predicted;
      while (!steady && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      {req_vol_a, req_vol_b, req_vol_c, req_vol_noise, req_step_a, req_step_b,
       req_step_c, req_duty_a, req_duty_b, req_duty_c} <= s;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      // model runs on every row so its state stays in step
      predicted = mix_sample(s);
      pending_mixes.push_back(known ? typed : predicted);
   endtask

   task automatic send_random(input int count);
      repeat (count)
         send_sample(random_sample(), 1'b0, '0);
   endtask

   // Drop valid and wait until every owed result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_mixes.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // APB write: setup then access, then idle with psel low so psel never toggles
   // twice in one step on back-to-back writes.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_tick_cfg(input pnom_pkg::tick_cfg_type cfg);
      csr_write(pnom_pkg::CSR_PRESET_ZERO, 32'(cfg.preset_zero));
      csr_write(pnom_pkg::CSR_PRESET_ONE,  32'(cfg.preset_one));
      csr_write(pnom_pkg::CSR_ENABLE_ZERO, 32'(cfg.enable_zero));
      csr_write(pnom_pkg::CSR_ENABLE_ONE,  32'(cfg.enable_one));
      tick_reload[0] = cfg.preset_zero;
      tick_reload[1] = cfg.preset_one;
      tick_on[0]     = cfg.enable_zero;
      tick_on[1]     = cfg.enable_one;
   endtask

   // Result side backpressure, ready low about 36 percent of the time outside the steady phase
   always @(posedge clock)
      rsp_ready <= steady || ($urandom_range(99) >= 36);

   // Each result transfer against the oldest owed result
   always @(posedge clock) begin
      mix_result_type owed;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_mixes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transfer: pcm_level %0d fire %b%b",
                        rsp_pcm_level, rsp_tick_fire_zero, rsp_tick_fire_one);
         end else begin
            owed = pending_mixes.pop_front();
            if (rsp_pcm_level !== owed.pcm_level ||
                rsp_tick_fire_zero !== owed.fire_zero ||
                rsp_tick_fire_one !== owed.fire_one) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mix mismatch: exp level %0d fire %b%b, got level %0d fire %b%b",
                           owed.pcm_level, owed.fire_zero, owed.fire_one,
                           rsp_pcm_level, rsp_tick_fire_zero, rsp_tick_fire_one);
            end
         end
      end
   end

   // Stimulus: directed table, random at reset settings (ends before the first
   // divider event at sample 256), then random over each tick setting.
   initial begin
      int                     row;
      int                     p;
      pnom_pkg::tick_cfg_type cfg;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++)
         send_sample(directed_rows[row].sample, directed_rows[row].known,
                     directed_rows[row].result);
      send_random(200);

      for (p = 0; p < PHASES; p++) begin
         drain();
         cfg = tick_settings[p];
         if (p == RANDOM_PHASE) begin
            cfg.preset_zero = 8'($urandom_range(5));
            cfg.preset_one  = 8'($urandom_range(5));
            cfg.enable_zero = 1'($urandom_range(1));
            cfg.enable_one  = 1'($urandom_range(1));
         end
         load_tick_cfg(cfg);
         steady = (p == STEADY_PHASE);
         send_random(190);
      end
      steady = 1'b0;

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("pulse_noise_oscillator_mixer regression: pass");
      else
         $display("pulse_noise_oscillator_mixer regression: fail");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #400_000;
      $display("pulse_noise_oscillator_mixer regression: fail");
      $finish;
   end

endmodule
